[rtl/core/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// sdspi_pkg
// shared types and constants for the sd card spi-mode host sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned ByteCntW    = $clog2(SectorBytes) + 1;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_REPLY = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_RDY  = 3'd1;
  localparam logic [2:0] ST_REJECT   = 3'd2;
  localparam logic [2:0] ST_TOKEN_TO = 3'd3;
  localparam logic [2:0] ST_WR_FAULT = 3'd4;
  localparam logic [2:0] ST_INIT_ERR = 3'd5;

  localparam logic [5:0] SD_CMD0  = 6'd0;
  localparam logic [5:0] SD_CMD8  = 6'd8;
  localparam logic [5:0] SD_CMD17 = 6'd17;
  localparam logic [5:0] SD_CMD24 = 6'd24;
  localparam logic [5:0] SD_CMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55 = 6'd55;
  localparam logic [5:0] SD_CMD58 = 6'd58;

  localparam logic [2:0] REG_READY_POLL = 3'd0;
  localparam logic [2:0] REG_REPLY_POLL = 3'd1;
  localparam logic [2:0] REG_RESET_ATT  = 3'd2;
  localparam logic [2:0] REG_OPCOND_ATT = 3'd3;
  localparam logic [2:0] REG_TOKEN_POLL = 3'd4;
  localparam logic [2:0] REG_BUSY_POLL  = 3'd5;
  localparam logic [2:0] REG_POWER_UP   = 3'd6;

  typedef enum logic [13:0] {
    PH_IDLE  = 14'h0001,
    PH_PWR   = 14'h0002,
    PH_RDY   = 14'h0004,
    PH_FRM   = 14'h0008,
    PH_R1    = 14'h0010,
    PH_TAIL  = 14'h0020,
    PH_TOK   = 14'h0040,
    PH_RDAT  = 14'h0080,
    PH_RCRC  = 14'h0100,
    PH_WTOK  = 14'h0200,
    PH_WDAT  = 14'h0400,
    PH_WCRC  = 14'h0800,
    PH_WRESP = 14'h1000,
    PH_BUSY  = 14'h2000
  } phase_t;

  typedef struct packed {
    logic [15:0] ready_poll;
    logic [7:0]  reply_poll;
    logic [7:0]  reset_att;
    logic [15:0] opcond_att;
    logic [15:0] token_poll;
    logic [15:0] busy_poll;
    logic [7:0]  power_up;
  } cfg_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       exchange;
    logic       chip_select_n;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic [2:0] status;
    logic       card_ready;
    logic       high_capacity;
  } res_t;

  function automatic logic [15:0] lim16(input logic [15:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sdspi_regs.sv]
// ----------------------------------------------------------------------------
// sdspi_regs
// apb-style configuration registers for the sequencer limits
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_regs
  import sdspi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_poll <= 16'd500;
      cfg_r.reply_poll <= 8'd50;
      cfg_r.reset_att  <= 8'd10;
      cfg_r.opcond_att <= 16'd1000;
      cfg_r.token_poll <= 16'd8000;
      cfg_r.busy_poll  <= 16'd1000;
      cfg_r.power_up   <= 8'd25;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_READY_POLL: cfg_r.ready_poll <= pwdata[15:0];
        REG_REPLY_POLL: cfg_r.reply_poll <= pwdata[7:0];
        REG_RESET_ATT:  cfg_r.reset_att  <= pwdata[7:0];
        REG_OPCOND_ATT: cfg_r.opcond_att <= pwdata[15:0];
        REG_TOKEN_POLL: cfg_r.token_poll <= pwdata[15:0];
        REG_BUSY_POLL:  cfg_r.busy_poll  <= pwdata[15:0];
        REG_POWER_UP:   cfg_r.power_up   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_READY_POLL: prdata = {16'd0, cfg_r.ready_poll};
      REG_REPLY_POLL: prdata = {24'd0, cfg_r.reply_poll};
      REG_RESET_ATT:  prdata = {24'd0, cfg_r.reset_att};
      REG_OPCOND_ATT: prdata = {16'd0, cfg_r.opcond_att};
      REG_TOKEN_POLL: prdata = {16'd0, cfg_r.token_poll};
      REG_BUSY_POLL:  prdata = {16'd0, cfg_r.busy_poll};
      REG_POWER_UP:   prdata = {24'd0, cfg_r.power_up};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/sd_card_spi_host_controller.sv]
// ----------------------------------------------------------------------------
// sd_card_spi_host_controller
// spi-mode sd card host sequencer: one spi byte exchange decided per item
// ----------------------------------------------------------------------------
// result: an accepted item's result item is registered and presented in the cycle after it is taken
// throughput: one item per cycle while the result register is not stalled; the sequencer step is one combinational pass
// the result register stalls independently; an item is taken while out is empty
// or being taken in the same cycle
// reset: synchronous active-low rst_n; idle phase, flags clear, limits at defaults
`default_nettype none

module sd_card_spi_host_controller
  import sdspi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_drive_index,
  input  wire logic [31:0] in_sector,
  input  wire logic [7:0]  in_sector_count,
  input  wire logic [7:0]  in_miso_byte,
  input  wire logic [7:0]  in_write_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_mosi_byte,
  output logic             out_exchange,
  output logic             out_chip_select_n,
  output logic [7:0]       out_read_data,
  output logic             out_read_valid,
  output logic             out_done_res,
  output logic [2:0]       out_status,
  output logic             out_card_ready,
  output logic             out_high_capacity,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  sdspi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phase_t               phase_r, phase_nxt;
  logic [2:0]           frame_r, frame_nxt;
  logic [5:0]           pcmd_r, pcmd_nxt;
  logic [31:0]          parg_r, parg_nxt;
  logic [15:0]          poll_r, poll_nxt;
  logic [15:0]          att_r, att_nxt;
  logic [ByteCntW-1:0]  bcnt_r, bcnt_nxt;
  logic [31:0]          shift_r, shift_nxt;
  logic                 v2_r, v2_nxt, ccs_r, ccs_nxt, rdy_r, rdy_nxt;
  logic [31:0]          csec_r, csec_nxt;
  logic [7:0]           left_r, left_nxt;
  res_t                 res_r, res;
  logic                 out_valid_r;
  logic                 take;

  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  logic [15:0] poll_inc;
  logic [15:0] att_inc;
  logic [ByteCntW-1:0] bcnt_inc;
  logic [31:0] sec_inc;
  logic [7:0]  left_dec;
  logic [7:0]  r1;

  assign poll_inc = poll_r + 16'd1;
  assign att_inc  = att_r + 16'd1;
  assign bcnt_inc = bcnt_r + 1'b1;
  assign sec_inc  = csec_r + 32'd1;
  assign left_dec = left_r - 8'd1;

  function automatic logic [7:0] frame_byte(input logic [2:0] i, input logic [5:0] c,
                                            input logic [31:0] a);
    case (i)
      3'd0:    return {2'b01, c};
      3'd1:    return a[31:24];
      3'd2:    return a[23:16];
      3'd3:    return a[15:8];
      3'd4:    return a[7:0];
      default: return (c == SD_CMD0) ? 8'h95 : ((c == SD_CMD8) ? 8'h87 : 8'h01);
    endcase
  endfunction

  always_comb begin
    phase_nxt = phase_r; frame_nxt = frame_r; pcmd_nxt = pcmd_r; parg_nxt = parg_r;
    poll_nxt = poll_r; att_nxt = att_r; bcnt_nxt = bcnt_r; shift_nxt = shift_r;
    v2_nxt = v2_r; ccs_nxt = ccs_r; rdy_nxt = rdy_r; csec_nxt = csec_r;
    left_nxt = left_r;
    r1 = 8'hFF;
    res = '0;
    res.mosi_byte = 8'hFF;
    res.chip_select_n = 1'b1;

    if (in_cmd != CMD_REPLY) begin
      phase_nxt = PH_IDLE;
      if (in_drive_index != 8'd0) begin
        res.done_res = 1'b1; res.status = ST_NOT_RDY;
      end else if (in_cmd == CMD_INIT) begin
        rdy_nxt = 1'b0; ccs_nxt = 1'b0; v2_nxt = 1'b0;
        phase_nxt = PH_PWR; poll_nxt = '0;
        res.exchange = 1'b1;
      end else if (!rdy_r) begin
        res.done_res = 1'b1; res.status = ST_NOT_RDY;
      end else if (in_sector_count == 8'd0) begin
        res.done_res = 1'b1; res.status = ST_OK;
      end else begin
        csec_nxt = in_sector; left_nxt = in_sector_count;
        pcmd_nxt = (in_cmd == CMD_READ) ? SD_CMD17 : SD_CMD24;
        parg_nxt = ccs_r ? in_sector : {in_sector[22:0], 9'd0};
        phase_nxt = PH_RDY; poll_nxt = '0;
        res.exchange = 1'b1; res.chip_select_n = 1'b0;
      end
    end else begin
      // default for continuing phases: exchange 0xff with card selected
      res.exchange = 1'b1; res.chip_select_n = 1'b0;
      case (phase_r)
        PH_PWR: begin
          poll_nxt = poll_inc;
          if (poll_inc < lim16({8'd0, cfg.power_up})) begin
            res.chip_select_n = 1'b1;
          end else begin
            att_nxt = '0; pcmd_nxt = SD_CMD0; parg_nxt = '0;
            phase_nxt = PH_RDY; poll_nxt = '0;
          end
        end
        PH_RDY: begin
          poll_nxt = poll_inc;
          if (in_miso_byte == 8'hFF || poll_inc >= lim16(cfg.ready_poll)) begin
            phase_nxt = PH_FRM; frame_nxt = 3'd0;
            res.mosi_byte = frame_byte(3'd0, pcmd_r, parg_r);
          end
        end
        PH_FRM: begin
          frame_nxt = frame_r + 3'd1;
          if (frame_r < 3'd5) begin
            res.mosi_byte = frame_byte(frame_r + 3'd1, pcmd_r, parg_r);
          end else begin
            phase_nxt = PH_R1; poll_nxt = '0;
          end
        end
        PH_R1: begin
          poll_nxt = poll_inc;
          if (!in_miso_byte[7] || poll_inc >= lim16({8'd0, cfg.reply_poll})) begin
            r1 = in_miso_byte[7] ? 8'hFF : in_miso_byte;
            case (pcmd_r)
              SD_CMD0: begin
                if (r1 == 8'h01) begin
                  pcmd_nxt = SD_CMD8; parg_nxt = 32'h1AA; phase_nxt = PH_RDY;
                  poll_nxt = '0;
                end else begin
                  att_nxt = att_inc;
                  if (att_inc >= lim16({8'd0, cfg.reset_att})) begin
                    phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_INIT_ERR;
                  end else begin
                    pcmd_nxt = SD_CMD0; parg_nxt = '0; phase_nxt = PH_RDY;
                    poll_nxt = '0;
                  end
                end
              end
              SD_CMD8: begin
                if (r1 == 8'h01) begin
                  phase_nxt = PH_TAIL; bcnt_nxt = '0; shift_nxt = '0;
                end else if (r1 == 8'h05) begin
                  v2_nxt = 1'b0; att_nxt = '0; pcmd_nxt = SD_CMD55; parg_nxt = '0;
                  phase_nxt = PH_RDY; poll_nxt = '0;
                end else begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_INIT_ERR;
                end
              end
              SD_CMD55, SD_CMD41: begin
                if (pcmd_r == SD_CMD55 && r1 <= 8'h01) begin
                  pcmd_nxt = SD_CMD41; parg_nxt = v2_r ? 32'h4000_0000 : 32'd0;
                  phase_nxt = PH_RDY; poll_nxt = '0;
                end else if (pcmd_r == SD_CMD41 && r1 == 8'h00) begin
                  if (v2_r) begin
                    pcmd_nxt = SD_CMD58; parg_nxt = '0; phase_nxt = PH_RDY;
                    poll_nxt = '0;
                  end else begin
                    ccs_nxt = 1'b0; rdy_nxt = 1'b1; phase_nxt = PH_IDLE;
                    res.done_res = 1'b1; res.status = ST_OK;
                  end
                end else if (pcmd_r == SD_CMD41 && r1 != 8'h01) begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_INIT_ERR;
                end else begin
                  att_nxt = att_inc;
                  if (att_inc >= lim16(cfg.opcond_att)) begin
                    phase_nxt = PH_IDLE; res.done_res = 1'b1;
                    res.status = ST_INIT_ERR;
                  end else begin
                    pcmd_nxt = SD_CMD55; parg_nxt = '0; phase_nxt = PH_RDY;
                    poll_nxt = '0;
                  end
                end
              end
              SD_CMD58: begin
                if (r1 == 8'h00) begin
                  phase_nxt = PH_TAIL; bcnt_nxt = '0; shift_nxt = '0;
                end else begin
                  ccs_nxt = 1'b0; rdy_nxt = 1'b1; phase_nxt = PH_IDLE;
                  res.done_res = 1'b1; res.status = ST_OK;
                end
              end
              SD_CMD17, SD_CMD24: begin
                if (r1 != 8'h00) begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_REJECT;
                end else if (pcmd_r == SD_CMD17) begin
                  phase_nxt = PH_TOK; poll_nxt = '0;
                end else begin
                  phase_nxt = PH_WTOK; res.mosi_byte = 8'hFE;
                end
              end
              default: begin
                phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_INIT_ERR;
              end
            endcase
          end
        end
        PH_TAIL: begin
          shift_nxt = {shift_r[23:0], in_miso_byte};
          bcnt_nxt = bcnt_inc;
          if (bcnt_inc >= ByteCntW'(4)) begin
            if (pcmd_r == SD_CMD8) begin
              if (in_miso_byte != 8'hAA) begin
                phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_INIT_ERR;
              end else begin
                v2_nxt = 1'b1; att_nxt = '0; pcmd_nxt = SD_CMD55; parg_nxt = '0;
                phase_nxt = PH_RDY; poll_nxt = '0;
              end
            end else begin
              ccs_nxt = shift_r[22]; rdy_nxt = 1'b1; phase_nxt = PH_IDLE;
              res.done_res = 1'b1; res.status = ST_OK;
            end
          end
        end
        PH_TOK: begin
          poll_nxt = poll_inc;
          if (in_miso_byte == 8'hFE) begin
            phase_nxt = PH_RDAT; bcnt_nxt = '0;
          end else if (poll_inc >= lim16(cfg.token_poll)) begin
            phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_TOKEN_TO;
          end
        end
        PH_RDAT: begin
          res.read_data = in_miso_byte; res.read_valid = 1'b1;
          bcnt_nxt = bcnt_inc;
          if (bcnt_inc >= ByteCntW'(SectorBytes)) begin
            phase_nxt = PH_RCRC; bcnt_nxt = '0;
          end
        end
        PH_WTOK: begin
          phase_nxt = PH_WDAT; bcnt_nxt = '0; res.mosi_byte = in_write_byte;
        end
        PH_WDAT: begin
          bcnt_nxt = bcnt_inc;
          if (bcnt_inc < ByteCntW'(SectorBytes)) begin
            res.mosi_byte = in_write_byte;
          end else begin
            phase_nxt = PH_WCRC; bcnt_nxt = '0;
          end
        end
        PH_RCRC, PH_WCRC: begin
          bcnt_nxt = bcnt_inc;
          if (bcnt_inc >= ByteCntW'(2)) begin
            if (phase_r == PH_WCRC) begin
              phase_nxt = PH_WRESP;
            end else begin
              csec_nxt = sec_inc; left_nxt = left_dec;
              if (left_dec == 8'd0) begin
                phase_nxt = PH_IDLE; res.exchange = 1'b0; res.chip_select_n = 1'b1;
                res.done_res = 1'b1; res.status = ST_OK;
              end else begin
                parg_nxt = ccs_r ? sec_inc : {sec_inc[22:0], 9'd0};
                phase_nxt = PH_RDY; poll_nxt = '0;
              end
            end
          end
        end
        PH_WRESP: begin
          if (in_miso_byte[4:0] != 5'h05) begin
            phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_WR_FAULT;
          end else begin
            phase_nxt = PH_BUSY; poll_nxt = '0;
          end
        end
        PH_BUSY: begin
          poll_nxt = poll_inc;
          if (in_miso_byte != 8'h00) begin
            csec_nxt = sec_inc; left_nxt = left_dec;
            if (left_dec == 8'd0) begin
              phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
            end else begin
              parg_nxt = ccs_r ? sec_inc : {sec_inc[22:0], 9'd0};
              phase_nxt = PH_RDY; poll_nxt = '0;
            end
          end else if (poll_inc >= lim16(cfg.busy_poll)) begin
            phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_WR_FAULT;
          end
        end
        default: begin
          // reply with nothing pending is ignored
          res.exchange = 1'b0; res.chip_select_n = 1'b1;
        end
      endcase
      if (res.done_res) begin
        res.exchange = 1'b0; res.chip_select_n = 1'b1; res.mosi_byte = 8'hFF;
      end
    end
    res.card_ready = rdy_nxt;
    res.high_capacity = ccs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; frame_r <= '0; pcmd_r <= '0; parg_r <= '0;
      poll_r <= '0; att_r <= '0; bcnt_r <= '0; shift_r <= '0;
      v2_r <= 1'b0; ccs_r <= 1'b0; rdy_r <= 1'b0; csec_r <= '0; left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; frame_r <= frame_nxt; pcmd_r <= pcmd_nxt;
        parg_r <= parg_nxt; poll_r <= poll_nxt; att_r <= att_nxt;
        bcnt_r <= bcnt_nxt; shift_r <= shift_nxt; v2_r <= v2_nxt;
        ccs_r <= ccs_nxt; rdy_r <= rdy_nxt; csec_r <= csec_nxt; left_r <= left_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_mosi_byte     = res_r.mosi_byte;
  assign out_exchange      = res_r.exchange;
  assign out_chip_select_n = res_r.chip_select_n;
  assign out_read_data     = res_r.read_data;
  assign out_read_valid    = res_r.read_valid;
  assign out_done_res      = res_r.done_res;
  assign out_status        = res_r.status;
  assign out_card_ready    = res_r.card_ready;
  assign out_high_capacity = res_r.high_capacity;

  a_done_no_xchg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_exchange && out_chip_select_n)
    else $error("done with exchange");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_OK)
    else $error("status without done");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mosi_byte))
    else $error("result lost under stall");

  a_rd_in_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_exchange && !out_chip_select_n)
    else $error("read byte outside transfer");

endmodule

`default_nettype wire

[tb/sv/tb_checker.sv]
// ----------------------------------------------------------------------------
// tb_checker
// watches both channels and the apb port of the sd spi sequencer, steps its
// own copy of the sequencer for every accepted item and compares each result
// item field by field against the oldest predicted one
// ----------------------------------------------------------------------------
module tb_checker
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_drive_index,
  input  logic [31:0] in_sector,
  input  logic [7:0]  in_sector_count,
  input  logic [7:0]  in_miso_byte,
  input  logic [7:0]  in_write_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_mosi_byte,
  input  logic        out_exchange,
  input  logic        out_chip_select_n,
  input  logic [7:0]  out_read_data,
  input  logic        out_read_valid,
  input  logic        out_done_res,
  input  logic [2:0]  out_status,
  input  logic        out_card_ready,
  input  logic        out_high_capacity,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // limits as last written
  logic [15:0] ready_lim, opcond_lim, token_lim, busy_lim;
  logic [7:0]  reply_lim, reset_lim, pwr_bytes;

  // sequencer copy
  phase_t      phase;
  logic [2:0]  frame_idx;
  logic [5:0]  pend_cmd;
  logic [31:0] pend_arg;
  logic [15:0] poll_cnt, attempt_cnt;
  logic [9:0]  byte_cnt;
  logic [31:0] reply_word;
  logic        v2_card, block_addr, card_up;
  logic [31:0] cur_sector;
  logic [7:0]  sectors_left;

  res_t nxt;
  res_t expected_q[$];

  function automatic logic [15:0] floor_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] i);
    case (i)
      3'd0: return 8'h40 | {2'b00, pend_cmd};
      3'd1: return pend_arg[31:24];
      3'd2: return pend_arg[23:16];
      3'd3: return pend_arg[15:8];
      3'd4: return pend_arg[7:0];
      default: begin
        if (pend_cmd == SD_CMD0) return 8'h95;
        if (pend_cmd == SD_CMD8) return 8'h87;
        return 8'h01;
      end
    endcase
  endfunction

  function automatic logic [31:0] card_addr(input logic [31:0] s);
    return block_addr ? s : {s[22:0], 9'd0};
  endfunction

  task automatic xfer(input logic [7:0] b, input logic csn);
    nxt.mosi_byte = b;
    nxt.exchange = 1'b1;
    nxt.chip_select_n = csn;
  endtask

  task automatic finish_req(input logic [2:0] st);
    phase = PH_IDLE;
    nxt.done_res = 1'b1;
    nxt.status = st;
    nxt.exchange = 1'b0;
    nxt.chip_select_n = 1'b1;
    nxt.mosi_byte = 8'hFF;
  endtask

  task automatic issue(input logic [5:0] c, input logic [31:0] arg);
    pend_cmd = c;
    pend_arg = arg;
    phase = PH_RDY;
    poll_cnt = '0;
    xfer(8'hFF, 1'b0);
  endtask

  task automatic init_done();
    card_up = 1'b1;
    finish_req(ST_OK);
  endtask

  task automatic start_op_cond();
    attempt_cnt = '0;
    issue(SD_CMD55, 32'd0);
  endtask

  task automatic op_cond_retry();
    attempt_cnt++;
    if (attempt_cnt >= floor_one(opcond_lim)) finish_req(ST_INIT_ERR);
    else issue(SD_CMD55, 32'd0);
  endtask

  task automatic next_sector(input logic [5:0] c);
    cur_sector = cur_sector + 32'd1;
    sectors_left = sectors_left - 8'd1;
    if (sectors_left == 8'd0) finish_req(ST_OK);
    else issue(c, card_addr(cur_sector));
  endtask

  task automatic start_tail();
    phase = PH_TAIL;
    byte_cnt = '0;
    reply_word = '0;
    xfer(8'hFF, 1'b0);
  endtask

  task automatic take_r1(input logic [7:0] r);
    case (pend_cmd)
      SD_CMD0: begin
        if (r == 8'h01) issue(SD_CMD8, 32'h1AA);
        else begin
          attempt_cnt++;
          if (attempt_cnt >= floor_one({8'd0, reset_lim})) finish_req(ST_INIT_ERR);
          else issue(SD_CMD0, 32'd0);
        end
      end
      SD_CMD8: begin
        if (r == 8'h01) start_tail();
        else if (r == 8'h05) begin
          v2_card = 1'b0;
          start_op_cond();
        end else finish_req(ST_INIT_ERR);
      end
      SD_CMD55: begin
        if (r > 8'h01) op_cond_retry();
        else issue(SD_CMD41, v2_card ? 32'h4000_0000 : 32'd0);
      end
      SD_CMD41: begin
        if (r == 8'h00) begin
          if (v2_card) issue(SD_CMD58, 32'd0);
          else begin
            block_addr = 1'b0;
            init_done();
          end
        end else if (r != 8'h01) finish_req(ST_INIT_ERR);
        else op_cond_retry();
      end
      SD_CMD58: begin
        if (r == 8'h00) start_tail();
        else begin
          block_addr = 1'b0;
          init_done();
        end
      end
      SD_CMD17: begin
        if (r != 8'h00) finish_req(ST_REJECT);
        else begin
          phase = PH_TOK;
          poll_cnt = '0;
          xfer(8'hFF, 1'b0);
        end
      end
      SD_CMD24: begin
        if (r != 8'h00) finish_req(ST_REJECT);
        else begin
          phase = PH_WTOK;
          xfer(8'hFE, 1'b0);
        end
      end
      default: finish_req(ST_INIT_ERR);
    endcase
  endtask

  task automatic step_sequencer(input logic [1:0] cmd, input logic [7:0] drv,
                                input logic [31:0] sec, input logic [7:0] cnt,
                                input logic [7:0] miso, input logic [7:0] wb);
    nxt = '0;
    nxt.mosi_byte = 8'hFF;
    nxt.chip_select_n = 1'b1;
    if (cmd != CMD_REPLY) begin
      // any request drops what is in progress
      phase = PH_IDLE;
      if (drv != 8'd0) finish_req(ST_NOT_RDY);
      else if (cmd == CMD_INIT) begin
        card_up = 1'b0;
        block_addr = 1'b0;
        v2_card = 1'b0;
        phase = PH_PWR;
        poll_cnt = '0;
        xfer(8'hFF, 1'b1);
      end else if (!card_up) finish_req(ST_NOT_RDY);
      else if (cnt == 8'd0) finish_req(ST_OK);
      else begin
        cur_sector = sec;
        sectors_left = cnt;
        issue((cmd == CMD_READ) ? SD_CMD17 : SD_CMD24, card_addr(sec));
      end
    end else begin
      case (phase)
        PH_PWR: begin
          poll_cnt++;
          if (poll_cnt < floor_one({8'd0, pwr_bytes})) xfer(8'hFF, 1'b1);
          else begin
            attempt_cnt = '0;
            issue(SD_CMD0, 32'd0);
          end
        end
        PH_RDY: begin
          poll_cnt++;
          if (miso == 8'hFF || poll_cnt >= floor_one(ready_lim)) begin
            phase = PH_FRM;
            frame_idx = '0;
            xfer(frame_byte(3'd0), 1'b0);
          end else xfer(8'hFF, 1'b0);
        end
        PH_FRM: begin
          frame_idx++;
          if (frame_idx < 3'd6) xfer(frame_byte(frame_idx), 1'b0);
          else begin
            phase = PH_R1;
            poll_cnt = '0;
            xfer(8'hFF, 1'b0);
          end
        end
        PH_R1: begin
          poll_cnt++;
          if (!miso[7]) take_r1(miso);
          else if (poll_cnt >= floor_one({8'd0, reply_lim})) take_r1(8'hFF);
          else xfer(8'hFF, 1'b0);
        end
        PH_TAIL: begin
          reply_word = {reply_word[23:0], miso};
          byte_cnt++;
          if (byte_cnt < 10'd4) xfer(8'hFF, 1'b0);
          else if (pend_cmd == SD_CMD8) begin
            if (reply_word[7:0] != 8'hAA) finish_req(ST_INIT_ERR);
            else begin
              v2_card = 1'b1;
              start_op_cond();
            end
          end else begin
            block_addr = reply_word[30];
            init_done();
          end
        end
        PH_TOK: begin
          poll_cnt++;
          if (miso == 8'hFE) begin
            phase = PH_RDAT;
            byte_cnt = '0;
            xfer(8'hFF, 1'b0);
          end else if (poll_cnt >= floor_one(token_lim)) finish_req(ST_TOKEN_TO);
          else xfer(8'hFF, 1'b0);
        end
        PH_RDAT: begin
          nxt.read_data = miso;
          nxt.read_valid = 1'b1;
          byte_cnt++;
          if (byte_cnt < 10'd512) xfer(8'hFF, 1'b0);
          else begin
            phase = PH_RCRC;
            byte_cnt = '0;
            xfer(8'hFF, 1'b0);
          end
        end
        PH_RCRC: begin
          byte_cnt++;
          if (byte_cnt < 10'd2) xfer(8'hFF, 1'b0);
          else next_sector(SD_CMD17);
        end
        PH_WTOK: begin
          phase = PH_WDAT;
          byte_cnt = '0;
          xfer(wb, 1'b0);
        end
        PH_WDAT: begin
          byte_cnt++;
          if (byte_cnt < 10'd512) xfer(wb, 1'b0);
          else begin
            phase = PH_WCRC;
            byte_cnt = '0;
            xfer(8'hFF, 1'b0);
          end
        end
        PH_WCRC: begin
          byte_cnt++;
          if (byte_cnt < 10'd2) xfer(8'hFF, 1'b0);
          else begin
            phase = PH_WRESP;
            xfer(8'hFF, 1'b0);
          end
        end
        PH_WRESP: begin
          if (miso[4:0] != 5'h05) finish_req(ST_WR_FAULT);
          else begin
            phase = PH_BUSY;
            poll_cnt = '0;
            xfer(8'hFF, 1'b0);
          end
        end
        PH_BUSY: begin
          poll_cnt++;
          if (miso != 8'h00) next_sector(SD_CMD24);
          else if (poll_cnt >= floor_one(busy_lim)) finish_req(ST_WR_FAULT);
          else xfer(8'hFF, 1'b0);
        end
        default: ;
      endcase
    end
    nxt.card_ready = card_up;
    nxt.high_capacity = block_addr;
    expected_q.push_back(nxt);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      ready_lim = 16'd500;
      reply_lim = 8'd50;
      reset_lim = 8'd10;
      opcond_lim = 16'd1000;
      token_lim = 16'd8000;
      busy_lim = 16'd1000;
      pwr_bytes = 8'd25;
      phase = PH_IDLE;
      frame_idx = '0;
      pend_cmd = '0;
      pend_arg = '0;
      poll_cnt = '0;
      attempt_cnt = '0;
      byte_cnt = '0;
      reply_word = '0;
      v2_card = 1'b0;
      block_addr = 1'b0;
      card_up = 1'b0;
      cur_sector = '0;
      sectors_left = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_READY_POLL: ready_lim = pwdata[15:0];
          REG_REPLY_POLL: reply_lim = pwdata[7:0];
          REG_RESET_ATT:  reset_lim = pwdata[7:0];
          REG_OPCOND_ATT: opcond_lim = pwdata[15:0];
          REG_TOKEN_POLL: token_lim = pwdata[15:0];
          REG_BUSY_POLL:  busy_lim = pwdata[15:0];
          REG_POWER_UP:   pwr_bytes = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result item with nothing expected, mosi %0h", $time,
                   out_mosi_byte);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("mosi_byte", want.mosi_byte, out_mosi_byte);
          check_field("exchange", want.exchange, out_exchange);
          check_field("chip_select_n", want.chip_select_n, out_chip_select_n);
          check_field("read_data", want.read_data, out_read_data);
          check_field("read_valid", want.read_valid, out_read_valid);
          check_field("done_res", want.done_res, out_done_res);
          check_field("status", want.status, out_status);
          check_field("card_ready", want.card_ready, out_card_ready);
          check_field("high_capacity", want.high_capacity, out_high_capacity);
        end
      end
      if (in_valid && !in_stall)
        step_sequencer(in_cmd, in_drive_index, in_sector, in_sector_count,
                       in_miso_byte, in_write_byte);
    end
    pending = expected_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives the sd spi sequencer with requests and card-like reply streams
// (init, full and cut-short reads and writes, error paths and noise) across
// several limit settings, with random gaps and stalls; tb_checker does the checking
// ----------------------------------------------------------------------------
module tb_top
  import sdspi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_REPLY;
  logic [7:0]  in_drive_index = '0;
  logic [31:0] in_sector = '0;
  logic [7:0]  in_sector_count = '0;
  logic [7:0]  in_miso_byte = '0;
  logic [7:0]  in_write_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_mosi_byte;
  logic        out_exchange;
  logic        out_chip_select_n;
  logic [7:0]  out_read_data;
  logic        out_read_valid;
  logic        out_done_res;
  logic [2:0]  out_status;
  logic        out_card_ready;
  logic        out_high_capacity;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  // limits as written, so the card-side stimulus can stay inside them
  int unsigned cfg_val[7] = '{500, 50, 10, 1000, 8000, 1000, 25};

  always #1 clk = ~clk;

  sd_card_spi_host_controller i_dut (.*);

  tb_checker i_checker (.*);

  function automatic int unsigned eff(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // polls that stay below a limit, so the sequence is not cut short
  function automatic int unsigned polls_under(input int unsigned lim_v);
    int unsigned hi;
    hi = eff(lim_v) - 1;
    if (hi > 3) hi = 3;
    return $urandom_range(hi, 0);
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [7:0] drv, input logic [31:0] sec,
                      input logic [7:0] cnt, input logic [7:0] miso, input logic [7:0] wb);
    int unsigned pick, gap;
    pick = $urandom_range(99, 0);
    gap = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd = cmd;
    in_drive_index = drv;
    in_sector = sec;
    in_sector_count = cnt;
    in_miso_byte = miso;
    in_write_byte = wb;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic reply(input logic [7:0] miso);
    send(CMD_REPLY, 8'($urandom), 32'($urandom), 8'($urandom), miso, 8'($urandom));
  endtask

  // one command frame: ready polls, six frame bytes, r1 polls, r1
  task automatic run_cmd(input logic [7:0] r1);
    repeat (polls_under(cfg_val[REG_READY_POLL])) reply(8'($urandom_range(254, 0)));
    reply(8'hFF);
    repeat (6) reply(8'($urandom));
    repeat (polls_under(cfg_val[REG_REPLY_POLL])) reply(8'h80 | 8'($urandom_range(127, 0)));
    reply(r1);
  endtask

  task automatic do_init(input bit v2, input bit ccs);
    int unsigned retries;
    send(CMD_INIT, 8'd0, 32'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    repeat (eff(cfg_val[REG_POWER_UP])) reply(8'($urandom));
    repeat ($urandom_range(polls_under(cfg_val[REG_RESET_ATT]), 0)) run_cmd(8'h00);
    run_cmd(8'h01);
    if (v2) begin
      run_cmd(8'h01);
      repeat (2) reply(8'($urandom));
      reply(8'h01);
      reply(8'hAA);
    end else run_cmd(8'h05);
    retries = polls_under(cfg_val[REG_OPCOND_ATT]);
    repeat (retries) begin
      run_cmd(8'h01);
      run_cmd(8'h01);
    end
    run_cmd(8'h00);
    run_cmd(8'h00);
    if (v2) begin
      run_cmd(8'h00);
      reply({1'b1, ccs, 6'($urandom)});
      repeat (3) reply(8'($urandom));
    end
  endtask

  // nbytes below a full sector plus crc leaves the read cut short
  task automatic do_read(input logic [31:0] sec, input logic [7:0] cnt,
                         input int unsigned nbytes);
    send(CMD_READ, 8'd0, sec, cnt, 8'($urandom), 8'($urandom));
    repeat (cnt) begin
      run_cmd(8'h00);
      repeat (polls_under(cfg_val[REG_TOKEN_POLL])) reply(8'hFF);
      reply(8'hFE);
      repeat (nbytes) reply(8'($urandom));
    end
  endtask

  // nbytes of a full sector plus token reply and crc completes the write
  task automatic do_write(input logic [31:0] sec, input logic [7:0] cnt,
                          input int unsigned nbytes);
    send(CMD_WRITE, 8'd0, sec, cnt, 8'($urandom), 8'($urandom));
    repeat (cnt) begin
      run_cmd(8'h00);
      repeat (nbytes) reply(8'($urandom));
      if (nbytes == SectorBytes + 3) begin
        reply({3'($urandom), 5'h05});
        repeat (polls_under(cfg_val[REG_BUSY_POLL])) reply(8'h00);
        reply(8'($urandom_range(255, 1)));
      end
    end
  endtask

  task automatic noise(input int unsigned n);
    repeat (n)
      send(2'($urandom), ($urandom_range(1, 0) != 0) ? 8'd0 : 8'($urandom),
           32'($urandom), 8'($urandom_range(3, 0)), 8'($urandom), 8'($urandom));
  endtask

  // write registers only once everything predicted has come back
  task automatic set_limits(input int unsigned v[7]);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    for (int i = 0; i < 7; i++) begin
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = 5'(i * 4);
      pwdata = v[i];
      @(negedge clk);
      penable = 1'b1;
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      cfg_val[i] = v[i];
    end
  endtask

  task automatic episodes(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99, 0);
      if (pick < 25) do_init($urandom_range(3, 0) != 0, $urandom_range(1, 0));
      else if (pick < 45) do_read(32'($urandom), 8'd1, $urandom_range(40, 0));
      else if (pick < 65) do_write(32'($urandom), 8'd1, $urandom_range(40, 0));
      else if (pick < 85) noise($urandom_range(30, 5));
      else begin
        // broken sequence: a full init, then noise requests and garbage replies
        do_init(1'b1, 1'b0);
        noise($urandom_range(20, 1));
        repeat ($urandom_range(40, 5)) reply(8'($urandom));
      end
    end
  endtask

  // receiver: random stall stretches, plus one long hold-off while items keep coming
  initial begin
    int unsigned cyc, mode, len;
    bit held;
    cyc = 0;
    held = 0;
    wait (rst_n);
    forever begin
      if (!held && cyc > 800) begin
        held = 1;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        cyc += 300;
      end
      mode = $urandom_range(9, 0);
      len = $urandom_range(60, 5);
      repeat (len) begin
        @(negedge clk);
        cyc++;
        if (mode < 5) out_stall = 1'b0;
        else if (mode < 9) out_stall = ($urandom_range(9, 0) < 3);
        else out_stall = 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: requests before init, bad drive, idle reply, then clean inits and transfers
    send(CMD_INIT, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    send(CMD_READ, 8'd0, 32'd0, 8'd1, 8'h00, 8'h00);
    send(CMD_WRITE, 8'd0, 32'd5, 8'd1, 8'h00, 8'h00);
    reply(8'h00);
    set_limits('{1, 1, 1, 1, 1, 1, 1});
    do_init(1'b1, 1'b1);
    send(CMD_READ, 8'd1, 32'd0, 8'd1, 8'h00, 8'h00);
    send(CMD_WRITE, 8'd0, 32'd0, 8'd0, 8'h00, 8'h00);
    do_read(32'hFFFF_FFFF, 8'd1, SectorBytes + 2);
    do_init(1'b0, 1'b0);
    do_write(32'h0080_0001, 8'd1, SectorBytes + 3);
    episodes(1);

    set_limits('{65535, 255, 255, 65535, 65535, 65535, 255});
    do_init(1'b1, 1'b0);
    do_write(32'hFFFF_FFFF, 8'd2, 30);
    episodes(1);

    set_limits('{0, 0, 0, 0, 0, 0, 0});
    episodes(1);

    set_limits('{$urandom_range(20, 2), $urandom_range(20, 2), $urandom_range(5, 2),
                 $urandom_range(20, 2), $urandom_range(20, 2), $urandom_range(20, 2),
                 $urandom_range(12, 1)});
    episodes(2);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
